// ----- src/aslist_pkg.sv -----
// Package for the semaphore wait-queue manager.
// Holds command and status codes and the controller/datapath interface types.
package aslist_pkg;

  typedef enum logic [1:0] {
    CMD_BLOCK   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_WAITING  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_UPDATE
  } fsm_e;

  typedef struct packed {
    logic capture;
    logic update;
  } ctrl_t;

endpackage

// ----- src/aslist_ctrl.sv -----
// Controller for the semaphore wait-queue manager.
// Sequences capture, lookup and update; depends on aslist_pkg.
module aslist_ctrl import aslist_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.update  = 1'b0;
    busy_o         = 1'b1;
    unique case (state_q)
      FSM_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = FSM_LOOKUP;
        end
      end
      FSM_LOOKUP: state_d = FSM_UPDATE;
      FSM_UPDATE: begin
        ctrl_o.update = 1'b1;
        state_d       = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  a_update_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.update |-> $past(state_q) == FSM_LOOKUP)
    else $error("update without lookup");
  a_capture_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> busy_o)
    else $error("not busy after capture");
  a_update_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.update |=> !busy_o)
    else $error("not idle after update");

endmodule

// ----- src/aslist_dp.sv -----
// Datapath for the semaphore wait-queue manager: descriptor and link tables,
// key match and free search. Depends on aslist_pkg.
module aslist_dp import aslist_pkg::*; #(
  parameter int unsigned PROC_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] sem_key_i,
  input  logic [4:0]  proc_id_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        proc_valid_o,
  output logic [4:0]  result_proc_o
);

  localparam int unsigned IW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  typedef logic [IW-1:0] idx_t;

  logic [31:0] slot_key_q  [PROC_COUNT];
  idx_t        slot_head_q [PROC_COUNT];
  idx_t        slot_tail_q [PROC_COUNT];
  idx_t        proc_next_q [PROC_COUNT];
  idx_t        proc_prev_q [PROC_COUNT];
  idx_t        proc_slot_q [PROC_COUNT];
  logic [PROC_COUNT-1:0] slot_use_q, proc_wait_q;

  logic [1:0]  cmd_q;
  logic [31:0] key_q;
  logic [4:0]  pid_q;

  // lookup results registered between capture and update
  logic        hit_q, free_q, pid_ok_q;
  idx_t        hit_idx_q, free_idx_q;

  logic        hit_d, free_d;
  idx_t        hit_idx_d, free_idx_d;

  always_comb begin
    hit_d = 1'b0; hit_idx_d = '0; free_d = 1'b0; free_idx_d = '0;
    for (int i = PROC_COUNT - 1; i >= 0; i--) begin
      if (slot_use_q[i] && slot_key_q[i] == key_q) begin
        hit_d = 1'b1; hit_idx_d = idx_t'(i);
      end
      if (!slot_use_q[i]) begin
        free_d = 1'b1; free_idx_d = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      key_q <= sem_key_i;
      pid_q <= proc_id_i;
    end
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    pid_ok_q   <= (32'(pid_q) < PROC_COUNT);
  end

  // update stage
  idx_t pid, head, victim, vs, vp, vn;
  logic do_block_hit, do_block_new, do_unlink;
  logic v_head, v_tail;
  logic [1:0] st;
  logic       pv;
  logic [4:0] rp;

  always_comb begin
    pid = idx_t'(pid_q);
    head = slot_head_q[hit_idx_q];
    do_block_hit = 1'b0; do_block_new = 1'b0; do_unlink = 1'b0;
    victim = pid;
    st = ST_NOTFOUND; pv = 1'b0; rp = '0;
    unique case (cmd_e'(cmd_q))
      CMD_BLOCK: begin
        if (!pid_ok_q) st = ST_NOTFOUND;
        else if (proc_wait_q[pid]) st = ST_WAITING;
        else if (hit_q) begin st = ST_OK; do_block_hit = 1'b1; end
        else if (free_q) begin st = ST_OK; do_block_new = 1'b1; end
        else st = ST_NOFREE;
      end
      CMD_RELEASE, CMD_PEEK: begin
        if (hit_q) begin
          st = ST_OK; pv = 1'b1; rp = 5'(head); victim = head;
          do_unlink = (cmd_q == CMD_RELEASE);
        end
      end
      CMD_REMOVE: begin
        if (pid_ok_q && proc_wait_q[pid]) begin
          st = ST_OK; pv = 1'b1; rp = pid_q; do_unlink = 1'b1;
        end
      end
      default: ;
    endcase
    vs = proc_slot_q[victim];
    vp = proc_prev_q[victim];
    vn = proc_next_q[victim];
    v_head = slot_head_q[vs] == victim;
    v_tail = slot_tail_q[vs] == victim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_use_q <= '0;
      proc_wait_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= ctrl_i.update;
      if (ctrl_i.update) begin
        if (do_block_hit || do_block_new) proc_wait_q[pid] <= 1'b1;
        if (do_block_new) slot_use_q[free_idx_q] <= 1'b1;
        if (do_unlink) begin
          proc_wait_q[victim] <= 1'b0;
          if (v_head && v_tail) slot_use_q[vs] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      status_o <= st; proc_valid_o <= pv; result_proc_o <= rp;
      if (do_block_hit) begin
        proc_next_q[slot_tail_q[hit_idx_q]] <= pid;
        proc_prev_q[pid] <= slot_tail_q[hit_idx_q];
        slot_tail_q[hit_idx_q] <= pid;
        proc_slot_q[pid] <= hit_idx_q;
      end
      if (do_block_new) begin
        slot_key_q[free_idx_q]  <= key_q;
        slot_head_q[free_idx_q] <= pid;
        slot_tail_q[free_idx_q] <= pid;
        proc_slot_q[pid]        <= free_idx_q;
      end
      if (do_unlink && !(v_head && v_tail)) begin
        if (v_head) slot_head_q[vs] <= vn;
        else if (v_tail) slot_tail_q[vs] <= vp;
        else begin
          proc_next_q[vp] <= vn;
          proc_prev_q[vn] <= vp;
        end
      end
    end
  end

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && proc_valid_o |-> status_o == ST_OK)
    else $error("process returned with error status");
  a_zero_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !proc_valid_o |-> result_proc_o == '0)
    else $error("stray result process");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

// ----- src/semaphore_wait_queue_manager.sv -----
// Semaphore wait-queue manager: each command passes through start, key lookup,
// update and result strobe before the next is accepted. busy is high from the
// cycle after acceptance through the result strobe cycle; the result shows for
// exactly one cycle with done_o and the receiver cannot stall it. Depends on aslist_pkg, aslist_ctrl, aslist_dp.
module semaphore_wait_queue_manager import aslist_pkg::*; #(
  parameter int unsigned PROC_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] sem_key_i,
  input  logic [4:0]  proc_id_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        proc_valid_o,
  output logic [4:0]  result_proc_o
);

  ctrl_t ctrl;
  logic  fsm_busy;

  aslist_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start & ~done_o), .busy_o(fsm_busy), .ctrl_o(ctrl)
  );

  assign busy = fsm_busy | done_o;

  aslist_dp #(.PROC_COUNT(PROC_COUNT)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl & {2{!done_o}}),
    .command_i, .sem_key_i, .proc_id_i,
    .done_o, .status_o, .proc_valid_o, .result_proc_o
  );

endmodule

// ----- sim/tb_semaphore_wait_queue_manager.sv -----
// Testbench for semaphore_wait_queue_manager: directed table then random commands,
// every result checked against an in-bench wait-queue predictor.
// Depends on aslist_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_semaphore_wait_queue_manager;
  import aslist_pkg::*;

  localparam int NPROC   = 32;
  localparam int NRANDOM = 1930;
  localparam int LIMIT   = 400000;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] key;
    logic [4:0]  pid;
    logic        chk;
    status_e     st;
    logic        pv;
    logic [4:0]  rp;
  } row_t;

  typedef struct packed {
    status_e  st;
    logic     pv;
    logic [4:0] rp;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [31:0] sem_key_i = '0;
  logic [4:0]  proc_id_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic        proc_valid_o;
  logic [4:0]  result_proc_o;

  semaphore_wait_queue_manager dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: each key's waiters in arrival order
  logic [31:0] q_key [NPROC];
  logic        q_used [NPROC];
  logic [4:0]  q_pids [NPROC][$];
  logic        waiting [NPROC];
  int          slot_of [NPROC];

  res_t pending_res[$];
  int   errs = 0;
  int   cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errs++;
  endtask

  function automatic int find_key(input logic [31:0] k);
    for (int s = 0; s < NPROC; s++)
      if (q_used[s] && q_key[s] == k) return s;
    return -1;
  endfunction

  function automatic void drop_waiter(input int p);
    int s;
    s = slot_of[p];
    for (int i = 0; i < q_pids[s].size(); i++)
      if (q_pids[s][i] == p) begin
        q_pids[s].delete(i);
        break;
      end
    if (q_pids[s].size() == 0) q_used[s] = 1'b0;
    waiting[p] = 1'b0;
  endfunction

  function automatic res_t predict_queue(input cmd_e c, input logic [31:0] k,
                                         input logic [4:0] p);
    res_t r;
    int s;
    r = '{st: ST_NOTFOUND, pv: 1'b0, rp: '0};
    case (c)
      CMD_BLOCK: begin
        if (waiting[p]) r.st = ST_WAITING;
        else begin
          s = find_key(k);
          if (s < 0)
            for (int i = 0; i < NPROC; i++)
              if (!q_used[i]) begin
                s = i;
                q_used[i] = 1'b1;
                q_key[i] = k;
                break;
              end
          if (s < 0) r.st = ST_NOFREE;
          else begin
            q_pids[s].push_back(p);
            slot_of[p] = s;
            waiting[p] = 1'b1;
            r.st = ST_OK;
          end
        end
      end
      CMD_RELEASE, CMD_PEEK: begin
        s = find_key(k);
        if (s >= 0) begin
          r = '{st: ST_OK, pv: 1'b1, rp: q_pids[s][0]};
          if (c == CMD_RELEASE) drop_waiter(q_pids[s][0]);
        end
      end
      default: begin
        if (waiting[p]) begin
          r = '{st: ST_OK, pv: 1'b1, rp: p};
          drop_waiter(p);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (done_o) begin
      if (pending_res.size() == 0) report_mismatch("result with nothing pending");
      else begin
        e = pending_res.pop_front();
        if (status_o !== e.st)
          report_mismatch($sformatf("status %0d, want %0d", status_o, e.st));
        if (proc_valid_o !== e.pv)
          report_mismatch($sformatf("proc_valid %0b, want %0b", proc_valid_o, e.pv));
        if (result_proc_o !== e.rp)
          report_mismatch($sformatf("result_proc %0d, want %0d", result_proc_o, e.rp));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_semaphore_wait_queue_manager: errors");
      $finish;
    end
  end

  // drive one transaction; returns once accepted
  task automatic issue_cmd(input cmd_e c, input logic [31:0] k, input logic [4:0] p,
                           input logic chk, input res_t want, input bit gaps);
    res_t r;
    if (gaps && $urandom_range(3) == 0)
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    start     <= 1'b1;
    command_i <= c;
    sem_key_i <= k;
    proc_id_i <= p;
    do @(posedge clk_i); while (busy);
    r = predict_queue(c, k, p);
    if (chk && r != want)
      report_mismatch($sformatf("table row %0d/%h/%0d disagrees with prediction", c, k, p));
    pending_res.push_back(r);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // keys drawn mostly from a small set so queues form and collide
  logic [31:0] key_pool [8];

  initial begin
    row_t  tbl[$];
    cmd_e  c;
    int    roll;
    logic [31:0] k;

    foreach (q_used[i]) begin
      q_used[i] = 1'b0;
      waiting[i] = 1'b0;
      slot_of[i] = 0;
      q_key[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tbl = '{
      '{CMD_PEEK,    32'h0,        5'd0,  1, ST_NOTFOUND, 0, 5'd0},
      '{CMD_RELEASE, 32'hFFFFFFFF, 5'd0,  1, ST_NOTFOUND, 0, 5'd0},
      '{CMD_REMOVE,  32'h0,        5'd31, 1, ST_NOTFOUND, 0, 5'd0},
      '{CMD_BLOCK,   32'hFFFFFFFF, 5'd31, 1, ST_OK,       0, 5'd0},
      '{CMD_BLOCK,   32'hFFFFFFFF, 5'd31, 1, ST_WAITING,  0, 5'd0},
      '{CMD_BLOCK,   32'hFFFFFFFF, 5'd0,  1, ST_OK,       0, 5'd0},
      '{CMD_BLOCK,   32'hFFFFFFFF, 5'd7,  0, ST_OK,       0, 5'd0},
      '{CMD_PEEK,    32'hFFFFFFFF, 5'd0,  1, ST_OK,       1, 5'd31},
      '{CMD_REMOVE,  32'h0,        5'd0,  1, ST_OK,       1, 5'd0},
      '{CMD_RELEASE, 32'hFFFFFFFF, 5'd0,  1, ST_OK,       1, 5'd31},
      '{CMD_RELEASE, 32'hFFFFFFFF, 5'd0,  1, ST_OK,       1, 5'd7},
      '{CMD_PEEK,    32'hFFFFFFFF, 5'd0,  1, ST_NOTFOUND, 0, 5'd0},
      '{CMD_BLOCK,   32'h0,        5'd0,  1, ST_OK,       0, 5'd0},
      '{CMD_REMOVE,  32'h0,        5'd0,  1, ST_OK,       1, 5'd0}
    };
    foreach (tbl[i])
      issue_cmd(tbl[i].cmd, tbl[i].key, tbl[i].pid, tbl[i].chk,
                '{st: tbl[i].st, pv: tbl[i].pv, rp: tbl[i].rp}, 1);

    // fill the pool: 32 distinct keys, every process waiting, so a block on a new key gets ST_WAITING
    for (int p = 0; p < NPROC; p++)
      issue_cmd(CMD_BLOCK, 32'hA000_0000 + p, p[4:0], 0, '0, 0);
    issue_cmd(CMD_BLOCK, 32'h5555_AAAA, 5'd3, 1, '{st: ST_WAITING, pv: 0, rp: 0}, 0);
    issue_cmd(CMD_REMOVE, 32'h0, 5'd3, 1, '{st: ST_OK, pv: 1, rp: 5'd3}, 0);
    issue_cmd(CMD_BLOCK, 32'h5555_AAAA, 5'd3, 1, '{st: ST_OK, pv: 0, rp: 0}, 0);
    issue_cmd(CMD_REMOVE, 32'h0, 5'd3, 0, '0, 0);
    issue_cmd(CMD_REMOVE, 32'h0, 5'd4, 0, '0, 0);
    issue_cmd(CMD_BLOCK, 32'h1234_5678, 5'd4, 0, '0, 0);
    issue_cmd(CMD_BLOCK, 32'h1234_5679, 5'd3, 0, '0, 0);
    issue_cmd(CMD_REMOVE, 32'h0, 5'd5, 0, '0, 0);
    issue_cmd(CMD_BLOCK, 32'h9999_9999, 5'd5, 0, '0, 0);
    for (int p = 0; p < NPROC; p++)
      issue_cmd(CMD_REMOVE, 32'h0, p[4:0], 0, '0, 0);

    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFFFFFF;
    for (int n = 0; n < NRANDOM; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) c = CMD_BLOCK;
      else if (roll < 65) c = CMD_RELEASE;
      else if (roll < 85) c = CMD_REMOVE;
      else c = CMD_PEEK;
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
      if (n % 300 == 0) key_pool[$urandom_range(2, 7)] = $urandom();
      issue_cmd(c, k, 5'($urandom_range(31)), 0, '0, n < NRANDOM - 200);
    end

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errs == 0)
      $display("tb_semaphore_wait_queue_manager: clean");
    else
      $display("tb_semaphore_wait_queue_manager: errors");
    $finish;
  end

endmodule
